// File: rtl/two_class_priority_fifo_top_macros.svh
// Assertion macros shared by the two-class priority FIFO design files.
// Every check is sampled on the rising edge of clk and is switched off while rst_n is low.
`ifndef TWO_CLASS_PRIORITY_FIFO_TOP_MACROS_SVH
`define TWO_CLASS_PRIORITY_FIFO_TOP_MACROS_SVH

// Checks that an implication holds on every clock edge.
`define TCPF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition is never true.
`define TCPF_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/tcpf_pkg.sv
`timescale 1ns / 1ps

package tcpf_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int KEY_W     = 8;
  localparam int PAYLOAD_W = 16;
  localparam int STATUS_W  = 3;

  localparam logic [KEY_W-1:0] THRESHOLD_RST = 8'd60;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SERVE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INS_PRIO = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INS_NORM = 3'd1;
  localparam logic [STATUS_W-1:0] ST_SRV_PRIO = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SRV_NORM = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd5;

  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
  } entry_t;

  // Commands from the scheduler to one queue.
  typedef struct packed {
    logic push;
    logic pop;
  } ring_ctl_t;

  // Occupancy flags from one queue to the scheduler.
  typedef struct packed {
    logic empty;
    logic full;
  } ring_sts_t;

endpackage

// File: rtl/tcpf_ring.sv
`timescale 1ns / 1ps
`include "two_class_priority_fifo_top_macros.svh"

module tcpf_ring #(
  parameter int DEPTH = tcpf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tcpf_pkg::ring_ctl_t ctl,
  input  tcpf_pkg::entry_t    wdata,
  output tcpf_pkg::entry_t    rdata,
  output tcpf_pkg::ring_sts_t sts
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  tcpf_pkg::entry_t mem [DEPTH];
  tcpf_pkg::entry_t rdata_r;

  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (ctl.push) begin
      tail_nxt = (tail_r == LAST) ? '0 : tail_r + 1'b1;
    end
    if (ctl.pop) begin
      head_nxt = (head_r == LAST) ? '0 : head_r + 1'b1;
    end
    if (ctl.push && !ctl.pop) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.pop && !ctl.push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // Storage: one write port at the tail, one registered read port at the head.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      rdata_r <= mem[head_r];
    end
  end

  assign rdata     = rdata_r;
  assign sts.empty = (count_r == '0);
  assign sts.full  = (count_r == FULL_CNT);

  `TCPF_ASSERT_NEVER(a_push_full, ctl.push && sts.full, "push into a full queue")
  `TCPF_ASSERT_NEVER(a_pop_empty, ctl.pop && sts.empty, "pop from an empty queue")
  `TCPF_ASSERT(a_cnt_up, (ctl.push && !ctl.pop) |=> count_r == $past(count_r) + 1'b1, "count did not rise")
  `TCPF_ASSERT(a_cnt_dn, (ctl.pop && !ctl.push) |=> count_r == $past(count_r) - 1'b1, "count did not fall")

endmodule

// File: rtl/two_class_priority_fifo_top.sv
`timescale 1ns / 1ps
`include "two_class_priority_fifo_top_macros.svh"

// Two-class priority FIFO: two circular queues served under strict priority.
// The input channel (in_valid, in_stall, in_opcode, in_key, in_payload) carries one
// item per handshake. An insert item goes to the priority queue when in_key is at or
// above the programmed threshold, and to the normal queue otherwise. A serve item takes
// the head of the priority queue first, then the head of the normal queue.
// Every item yields exactly one result item on the output channel (out_valid,
// out_stall, out_status, out_served_key, out_served_payload).
// An accepted item waits in the input register until the result register can load.
// Then the queues are updated, the queue memory is read and the result register loads
// together, raising out_valid. Throughput is one item per cycle while out_stall is low.
// The input register and the result register advance together, so a stalled result
// holds one item behind it before in_stall rises.
// The threshold is written through cfg_valid/cfg_ready/cfg_priority_threshold.
// Write it only while the block is idle. cfg_ready is always high.
// A synchronous reset (rst_n low) empties both queues and sets the threshold to 60.
// Queue storage is not cleared, because an entry is always written before it is read.
// While out_valid and out_stall are both high, the result register and the queue read data hold steady.
module two_class_priority_fifo_top #(
  parameter int QUEUE_DEPTH = tcpf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [7:0]  in_key,
  input  logic [15:0] in_payload,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [7:0]  out_served_key,
  output logic [15:0] out_served_payload,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_priority_threshold
);

  // Input register: one item waits here while its queue action is decided.
  logic        a_vld_r;
  logic        a_opcode_r;
  logic [7:0]  a_key_r;
  logic [15:0] a_payload_r;

  // Result register.
  logic        b_vld_r;
  logic [2:0]  b_status_r;
  logic [2:0]  status_nxt;

  logic [7:0]  thr_r;

  logic b_load;
  logic a_adv;
  logic in_acc;

  tcpf_pkg::ring_ctl_t pq_ctl, nq_ctl;
  tcpf_pkg::ring_sts_t pq_sts, nq_sts;
  tcpf_pkg::entry_t    a_entry, pq_rdata, nq_rdata;

  assign cfg_ready = 1'b1;

  // The result register loads whenever it is empty or being drained.
  assign b_load   = !b_vld_r || !out_stall;
  assign a_adv    = a_vld_r && b_load;
  assign in_stall = a_vld_r && !b_load;
  assign in_acc   = in_valid && !in_stall;

  assign a_entry.key     = a_key_r;
  assign a_entry.payload = a_payload_r;

  // Scheduler: queue commands fire only when the item moves on to the result register.
  always_comb begin
    pq_ctl     = '0;
    nq_ctl     = '0;
    status_nxt = tcpf_pkg::ST_EMPTY;
    unique case (a_opcode_r)
      tcpf_pkg::OP_INSERT: begin
        if (a_key_r >= thr_r) begin
          if (pq_sts.full) begin
            status_nxt = tcpf_pkg::ST_FULL;
          end else begin
            status_nxt  = tcpf_pkg::ST_INS_PRIO;
            pq_ctl.push = a_adv;
          end
        end else begin
          if (nq_sts.full) begin
            status_nxt = tcpf_pkg::ST_FULL;
          end else begin
            status_nxt  = tcpf_pkg::ST_INS_NORM;
            nq_ctl.push = a_adv;
          end
        end
      end
      tcpf_pkg::OP_SERVE: begin
        priority if (!pq_sts.empty) begin
          status_nxt = tcpf_pkg::ST_SRV_PRIO;
          pq_ctl.pop = a_adv;
        end else if (!nq_sts.empty) begin
          status_nxt = tcpf_pkg::ST_SRV_NORM;
          nq_ctl.pop = a_adv;
        end else begin
          status_nxt = tcpf_pkg::ST_EMPTY;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      thr_r   <= tcpf_pkg::THRESHOLD_RST;
    end else begin
      if (in_acc) begin
        a_vld_r <= 1'b1;
      end else if (a_adv) begin
        a_vld_r <= 1'b0;
      end
      if (b_load) begin
        b_vld_r <= a_vld_r;
      end
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_priority_threshold;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_opcode_r  <= in_opcode;
      a_key_r     <= in_key;
      a_payload_r <= in_payload;
    end
    if (b_load) begin
      b_status_r <= status_nxt;
    end
  end

  tcpf_ring #(
    .DEPTH (QUEUE_DEPTH)
  ) u_prio_q (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (pq_ctl),
    .wdata (a_entry),
    .rdata (pq_rdata),
    .sts   (pq_sts)
  );

  tcpf_ring #(
    .DEPTH (QUEUE_DEPTH)
  ) u_norm_q (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (nq_ctl),
    .wdata (a_entry),
    .rdata (nq_rdata),
    .sts   (nq_sts)
  );

  // Served fields come straight from the queue read registers, which only change on a pop.
  always_comb begin
    out_served_key     = '0;
    out_served_payload = '0;
    if (b_status_r == tcpf_pkg::ST_SRV_PRIO) begin
      out_served_key     = pq_rdata.key;
      out_served_payload = pq_rdata.payload;
    end else if (b_status_r == tcpf_pkg::ST_SRV_NORM) begin
      out_served_key     = nq_rdata.key;
      out_served_payload = nq_rdata.payload;
    end
  end

  assign out_valid  = b_vld_r;
  assign out_status = b_status_r;

  `TCPF_ASSERT_NEVER(a_two_ops, (pq_ctl.push || pq_ctl.pop) && (nq_ctl.push || nq_ctl.pop), "both queues acted on one item")
  `TCPF_ASSERT(a_status_rng, out_valid |-> out_status <= tcpf_pkg::ST_FULL, "result status out of range")
  `TCPF_ASSERT(a_adv_fill, a_adv |=> b_vld_r, "advanced item missing from result register")

endmodule

// File: bench/tb_two_class_priority_fifo_top.sv
`timescale 1ns / 1ps

module tb_two_class_priority_fifo_top;

  localparam int QD = tcpf_pkg::QUEUE_DEPTH_DEF;

  // Generous run limit. Even with every item waiting out the longest gap on
  // the input side and the longest stall on the output side, a correct run
  // stays far below this.
  localparam int CYCLE_LIMIT = 400000;

  // The two classes of the scheduler, used as indexes into the queue model.
  localparam int HI = 0;
  localparam int LO = 1;

  // One result item as the scheduler should produce it.
  typedef struct {
    logic [tcpf_pkg::STATUS_W-1:0]  status;
    logic [tcpf_pkg::KEY_W-1:0]     key;
    logic [tcpf_pkg::PAYLOAD_W-1:0] payload;
  } sched_result_t;

  // The scoreboard keeps its own copy of both queues and of the threshold.
  // It predicts one result for every accepted input item and compares each
  // accepted result with the oldest prediction.
  class sched_scoreboard;
    logic [tcpf_pkg::KEY_W-1:0] threshold;
    tcpf_pkg::entry_t           slot [2][QD];
    int unsigned                head [2];
    int unsigned                tail [2];
    int unsigned                fill [2];
    sched_result_t              awaited [$];
    int                         errors;

    function new();
      threshold = tcpf_pkg::THRESHOLD_RST;
      errors    = 0;
      for (int c = 0; c < 2; c++) begin
        head[c] = 0;
        tail[c] = 0;
        fill[c] = 0;
      end
    endfunction

    function void set_threshold(logic [tcpf_pkg::KEY_W-1:0] value);
      threshold = value;
    endfunction

    function void note_input(logic op, logic [tcpf_pkg::KEY_W-1:0] k,
                             logic [tcpf_pkg::PAYLOAD_W-1:0] p);
      sched_result_t    r;
      tcpf_pkg::entry_t e;
      int               c;
      r.key     = '0;
      r.payload = '0;
      if (op == tcpf_pkg::OP_INSERT) begin
        c = (k >= threshold) ? HI : LO;
        if (fill[c] == QD) begin
          r.status = tcpf_pkg::ST_FULL;
        end else begin
          e.key           = k;
          e.payload       = p;
          slot[c][tail[c]] = e;
          tail[c]         = (tail[c] + 1) % QD;
          fill[c]++;
          r.status = (c == HI) ? tcpf_pkg::ST_INS_PRIO : tcpf_pkg::ST_INS_NORM;
        end
      end else begin
        if (fill[HI] != 0) begin
          c = HI;
        end else if (fill[LO] != 0) begin
          c = LO;
        end else begin
          c = -1;
        end
        if (c < 0) begin
          r.status = tcpf_pkg::ST_EMPTY;
        end else begin
          e       = slot[c][head[c]];
          head[c] = (head[c] + 1) % QD;
          fill[c]--;
          r.status  = (c == HI) ? tcpf_pkg::ST_SRV_PRIO : tcpf_pkg::ST_SRV_NORM;
          r.key     = e.key;
          r.payload = e.payload;
        end
      end
      awaited.push_back(r);
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [tcpf_pkg::STATUS_W-1:0] st, logic [tcpf_pkg::KEY_W-1:0] k,
                      logic [tcpf_pkg::PAYLOAD_W-1:0] p);
      sched_result_t want;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, status %0d", st));
        return;
      end
      want = awaited.pop_front();
      if (st !== want.status) begin
        report_mismatch($sformatf("status got %0d, want %0d", st, want.status));
      end
      if (k !== want.key) begin
        report_mismatch($sformatf("served_key got %0h, want %0h", k, want.key));
      end
      if (p !== want.payload) begin
        report_mismatch($sformatf("served_payload got %0h, want %0h", p, want.payload));
      end
    endtask
  endclass

  // Every input of the block starts at a known value.
  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           in_opcode = tcpf_pkg::OP_INSERT;
  logic [tcpf_pkg::KEY_W-1:0]     in_key = '0;
  logic [tcpf_pkg::PAYLOAD_W-1:0] in_payload = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [tcpf_pkg::STATUS_W-1:0]  out_status;
  logic [tcpf_pkg::KEY_W-1:0]     out_served_key;
  logic [tcpf_pkg::PAYLOAD_W-1:0] out_served_payload;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [tcpf_pkg::KEY_W-1:0]     cfg_priority_threshold = '0;

  // When idle_on is low, neither side idles: the input side sends back to back
  // and the output side never stalls.
  bit                   idle_on = 1'b1;
  int                   cycles = 0;
  int                   stall_left = 0;

  sched_scoreboard sb = new();

  two_class_priority_fifo_top #(
    .QUEUE_DEPTH(QD)
  ) DUT (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_opcode              (in_opcode),
    .in_key                 (in_key),
    .in_payload             (in_payload),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_status             (out_status),
    .out_served_key         (out_served_key),
    .out_served_payload     (out_served_payload),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_priority_threshold (cfg_priority_threshold)
  );

  always #2 clk = ~clk;

  // Watchdog. A run that hangs anywhere ends here as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // The output side stalls in random bursts of random length. A burst starts
  // with its first stalled cycle, and stall_left counts the cycles that follow.
  always @(posedge clk) begin
    if (!rst_n || !idle_on) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 17) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // A result item is taken at every edge where out_valid is high and out_stall
  // is low. The values read here are the ones that stood before the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      sb.check_result(out_status, out_served_key, out_served_payload);
    end
  end

  // Sends one item and returns right after the edge that accepted it. The
  // item is noted in the scoreboard at that edge. Before the item, the input
  // side may idle for a burst of random length. When there is no gap, in_valid
  // simply stays high, so it gets exactly one assignment in this time step.
  task automatic send_item(input logic op, input logic [tcpf_pkg::KEY_W-1:0] k,
                           input logic [tcpf_pkg::PAYLOAD_W-1:0] p);
    int gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_opcode  <= op;
    in_key     <= k;
    in_payload <= p;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_input(op, k, p);
  endtask

  // Lowers in_valid and waits until every predicted result has come back.
  // Each item yields one result, so the block is idle from then on.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  // Writes the threshold register. Only called while the block is idle.
  task automatic write_threshold(input logic [tcpf_pkg::KEY_W-1:0] value);
    cfg_valid              <= 1'b1;
    cfg_priority_threshold <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    sb.set_threshold(value);
  endtask

  // Keys cluster around the threshold so that both sides of the compare are
  // hit often, with the extremes and fully random keys mixed in. The
  // subtraction and addition wrap, which is fine for a key.
  function automatic logic [tcpf_pkg::KEY_W-1:0] pick_key(
      input logic [tcpf_pkg::KEY_W-1:0] thr);
    case ($urandom_range(0, 6))
      0: return thr;
      1: return thr - 8'd1;
      2: return thr + 8'd1;
      3: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Random traffic in bursts of 8 to 40 items. An insert-heavy burst fills
  // the queues until inserts are refused as full, a serve-heavy burst drains
  // them into the empty case, and a balanced burst keeps them partly filled.
  // Serve items carry random key and payload, which the block must ignore.
  task automatic run_random(input int n);
    int  left;
    int  ins_pct;
    logic op;
    left    = 0;
    ins_pct = 50;
    for (int i = 0; i < n; i++) begin
      if (left == 0) begin
        left = $urandom_range(8, 40);
        case ($urandom_range(0, 2))
          0: ins_pct = 85;
          1: ins_pct = 20;
          default: ins_pct = 50;
        endcase
      end
      left--;
      op = ($urandom_range(0, 99) < ins_pct) ? tcpf_pkg::OP_INSERT : tcpf_pkg::OP_SERVE;
      send_item(op, pick_key(sb.threshold), 16'($urandom_range(0, 65535)));
    end
  endtask

  initial begin
    // Reset is held low from time zero and released once.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items under the reset threshold of 60. A serve on two empty
    // queues comes first. Then keys at the threshold, just below it, and at
    // both ends of the range go in with extreme payloads. The serves that
    // follow must return the priority entries first, each queue in order, and
    // then report empty again. The last serve carries all-ones key and payload,
    // which must not matter.
    send_item(tcpf_pkg::OP_SERVE,  8'd0,   16'h0000);
    send_item(tcpf_pkg::OP_INSERT, 8'd60,  16'hFFFF);
    send_item(tcpf_pkg::OP_INSERT, 8'd59,  16'h0000);
    send_item(tcpf_pkg::OP_INSERT, 8'd255, 16'hA5A5);
    send_item(tcpf_pkg::OP_INSERT, 8'd0,   16'h5A5A);
    send_item(tcpf_pkg::OP_INSERT, 8'd61,  16'h8001);
    send_item(tcpf_pkg::OP_INSERT, 8'd1,   16'h0001);
    repeat (6) send_item(tcpf_pkg::OP_SERVE, 8'd0, 16'h0000);
    send_item(tcpf_pkg::OP_SERVE,  8'hFF,  16'hFFFF);
    wait_idle();

    // Random phases, each under its own threshold. The first keeps the reset
    // value, then the register is driven to both extremes and in between.
    idle_on = ($urandom_range(0, 3) != 0);
    run_random(190);
    wait_idle();

    idle_on = ($urandom_range(0, 3) != 0);
    write_threshold(8'd0);
    run_random(180);
    wait_idle();

    idle_on = ($urandom_range(0, 3) != 0);
    write_threshold(8'd255);
    run_random(180);
    wait_idle();

    idle_on = 1'b1;
    write_threshold(8'($urandom_range(2, 253)));
    run_random(180);
    wait_idle();

    idle_on = ($urandom_range(0, 3) != 0);
    write_threshold(8'd1);
    run_random(180);
    wait_idle();

    // The last phase runs with no idling on either side.
    idle_on = 1'b0;
    write_threshold(8'd128);
    run_random(180);
    wait_idle();

    // Extra waiting lets any stray result show up as a mismatch.
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/tcpf_pkg.sv
rtl/tcpf_ring.sv
rtl/two_class_priority_fifo_top.sv
bench/tb_two_class_priority_fifo_top.sv
